/* rtl/emt_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the extent map translate/update block
// no dependencies
package emt_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [47:0] RESET_IMAGE_LEN = 48'd1073741824;
    localparam logic [47:0] U32_TOP         = 48'h0000_FFFF_FFFF;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_MAP    = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PAST    = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [47:0] base;
        logic [47:0] seq;
        logic [31:0] off;
        logic [47:0] len;
    } extent_t;

    localparam int ENTRY_W = $bits(extent_t);

    typedef struct packed {
        logic [47:0] start;
        logic [47:0] seq;
        logic [31:0] off;
        logic [47:0] len;
        logic        last;
        logic        corrupt;
    } frag_t;

endpackage

/* rtl/emt_if.sv */
`timescale 1ns / 1ps
// request and result channel interfaces
// depends on nothing
interface emt_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [47:0] range_start;
    logic [47:0] range_length;
    logic [47:0] new_seqnum;
    logic [31:0] new_object_offset;
    modport source (output valid, opcode, range_start, range_length, new_seqnum,
                    new_object_offset, input ready);
    modport sink (input valid, opcode, range_start, range_length, new_seqnum,
                  new_object_offset, output ready);
endinterface

interface emt_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] fragment_start;
    logic [47:0] fragment_seqnum;
    logic [31:0] fragment_object_offset;
    logic [47:0] fragment_length;
    logic [1:0]  status;
    logic        last;
    modport source (output valid, fragment_start, fragment_seqnum, fragment_object_offset,
                    fragment_length, status, last, input ready);
    modport sink (input valid, fragment_start, fragment_seqnum, fragment_object_offset,
                  fragment_length, status, last, output ready);
endinterface

/* rtl/emt_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module emt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/emt_frag.sv */
`timescale 1ns / 1ps
// trims one extent against the remaining lookup range
// depends on emt_pkg
module emt_frag (
    input  emt_pkg::extent_t ent,
    input  logic [47:0]      cur,
    input  logic [47:0]      rem,
    input  logic             first,
    output emt_pkg::frag_t   frag
);
    import emt_pkg::*;

    logic [47:0] skip;
    logic        big;
    logic [47:0] avail;

    always_comb
    begin
        skip  = first ? (cur - ent.base) : 48'd0;
        big   = (skip >= U32_TOP);
        avail = (ent.len > skip) ? (ent.len - skip) : 48'd0;
        frag.start   = cur;
        frag.seq     = ent.seq;
        // a skip too large for the object offset keeps the stored offset
        frag.off     = big ? ent.off : (ent.off + skip[31:0]);
        frag.last    = (rem <= avail);
        frag.len     = (rem <= avail) ? rem : avail;
        frag.corrupt = (big && (ent.seq != 48'd0)) || (avail == 48'd0);
    end
endmodule

/* rtl/extent_map_translate_update_core.sv */
`timescale 1ns / 1ps
// extent map translate/update: lookup fragments and map/unmap over a sorted table
// depends on emt_pkg, emt_if, emt_ram, emt_frag
// sequence: a request scans all stored extents, one per cycle, then a lookup passes a setup
//   state and gives one fragment a cycle while the result side is ready, and a map shifts
//   the tail and writes the left, new and right pieces; one request is handled at a time
// reset: one unmapped extent of 2^30 bytes, written to the table in the cycle after reset
module extent_map_translate_update_core (
    input  logic         clk,
    input  logic         rst_n,
    emt_req_if.sink      req,
    emt_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata
);
    import emt_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_LOOK, S_SHIFT,
        S_WLEFT, S_WNEW, S_WRIGHT, S_RESP
    } state_t;

    state_t           state_reg;
    logic [47:0]      image_len_reg;
    logic [CNT_W-1:0] count_reg;
    logic             op_reg;
    logic [47:0]      start_reg, len_reg, seq_reg, end_reg;
    logic [31:0]      off_reg;
    logic [47:0]      cur_reg, rem_reg;
    logic [CNT_W-1:0] scan_addr_reg;
    logic             scan_pend_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] i_reg, j_reg;
    extent_t          ent_i_reg, ent_j_reg;
    logic             left_reg, right_reg, first_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W:0]   newpos_reg, newcount_reg;
    logic [CNT_W-1:0] sh_rd_reg, sh_left_reg;
    logic             sh_up_reg;
    logic             wr_pend_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    logic [1:0]       st_reg;
    logic             echo_reg;

    logic             out_valid_reg;
    logic [47:0]      out_start_reg, out_seq_reg, out_len_reg;
    logic [31:0]      out_off_reg;
    logic [1:0]       out_status_reg;
    logic             out_last_reg;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    extent_t          ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;
    extent_t          frag_ent;
    frag_t            frag;
    logic             out_free;
    logic             out_load;

    logic [48:0]      req_sum;
    logic [47:0]      leftlen;
    logic [48:0]      rend;
    logic [CNT_W:0]   newpos_c, newcount_c, j1_c;

    emt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );
    assign ram_rdata = extent_t'(ram_rbits);

    assign frag_ent = first_reg ? ent_i_reg : ram_rdata;

    emt_frag u_frag (
        .ent   (frag_ent),
        .cur   (cur_reg),
        .rem   (rem_reg),
        .first (first_reg),
        .frag  (frag)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = out_free && !cfg_w_block() ;
    assign req.ready = (state_reg == S_IDLE);

    function automatic logic cfg_w_block();
        return cfg_we || !((state_reg == S_LOOK) || (state_reg == S_RESP));
    endfunction

    assign rsp.valid                  = out_valid_reg;
    assign rsp.fragment_start         = out_start_reg;
    assign rsp.fragment_seqnum        = out_seq_reg;
    assign rsp.fragment_object_offset = out_off_reg;
    assign rsp.fragment_length        = out_len_reg;
    assign rsp.status                 = out_status_reg;
    assign rsp.last                   = out_last_reg;

    always_comb
    begin
        req_sum    = {1'b0, req.range_start} + {1'b0, req.range_length};
        leftlen    = start_reg - ent_i_reg.base;
        rend       = {1'b0, ent_j_reg.base} + {1'b0, ent_j_reg.len};
        j1_c       = {2'b00, j_reg} + 8'(1);
        newpos_c   = {2'b00, i_reg} + 8'(leftlen != 48'd0) + 8'(1)
                     + 8'(rend > {1'b0, end_reg});
        newcount_c = newpos_c + {1'b0, count_reg} - j1_c;
    end

    // memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{base: 48'd0, seq: 48'd0, off: 32'd0, len: image_len_reg};
            end
            S_SCAN:
            begin
                ram_re    = (scan_addr_reg < count_reg);
                ram_raddr = scan_addr_reg[IDX_W-1:0];
            end
            S_LOOK:
            begin
                ram_re    = out_free && !frag.corrupt && !frag.last;
                ram_raddr = k_reg[IDX_W-1:0];
            end
            S_SHIFT:
            begin
                ram_we    = wr_pend_reg;
                ram_waddr = wr_addr_reg;
                ram_wdata = ram_rdata;
                ram_re    = (sh_left_reg != '0);
                ram_raddr = sh_rd_reg[IDX_W-1:0];
            end
            S_WLEFT:
            begin
                ram_we    = left_reg;
                ram_waddr = i_reg;
                ram_wdata = '{base: ent_i_reg.base, seq: ent_i_reg.seq,
                              off: ent_i_reg.off, len: leftlen};
            end
            S_WNEW:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg + IDX_W'(left_reg);
                ram_wdata = '{base: start_reg, seq: seq_reg, off: off_reg, len: len_reg};
            end
            S_WRIGHT:
            begin
                ram_we    = right_reg;
                ram_waddr = i_reg + IDX_W'(left_reg) + IDX_W'(1);
                ram_wdata = '{base: end_reg, seq: ent_j_reg.seq,
                              off: ent_j_reg.off + 32'(end_reg - ent_j_reg.base),
                              len: 48'(rend - {1'b0, end_reg})};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            image_len_reg <= RESET_IMAGE_LEN;
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                image_len_reg <= cfg_wdata;
                count_reg     <= CNT_W'(1);
                state_reg     <= S_INIT;
            end
            else
            begin
                case (state_reg)
                    S_INIT:
                    begin
                        count_reg <= CNT_W'(1);
                        state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (req.valid)
                        begin
                            op_reg    <= req.opcode;
                            start_reg <= req.range_start;
                            len_reg   <= req.range_length;
                            seq_reg   <= req.new_seqnum;
                            off_reg   <= (req.new_seqnum != 48'd0) ? req.new_object_offset
                                                                   : 32'd0;
                            end_reg   <= req_sum[47:0];
                            scan_addr_reg <= '0;
                            scan_pend_reg <= 1'b0;
                            if (req_sum > {1'b0, image_len_reg})
                            begin
                                st_reg    <= ST_PAST;
                                echo_reg  <= 1'b0;
                                state_reg <= S_RESP;
                            end
                            else if (req.range_length == 48'd0)
                            begin
                                st_reg    <= ST_OK;
                                echo_reg  <= (req.opcode == OP_MAP);
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                    S_SCAN:
                    begin
                        if (scan_addr_reg < count_reg)
                        begin
                            scan_pend_reg <= 1'b1;
                            scan_idx_reg  <= scan_addr_reg[IDX_W-1:0];
                            scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                        end
                        else
                        begin
                            scan_pend_reg <= 1'b0;
                            if (!scan_pend_reg)
                            begin
                                state_reg <= S_DECIDE;
                            end
                        end
                        // last extent whose base is at or below the range start / below the range end
                        if (scan_pend_reg && ram_rdata.base <= start_reg)
                        begin
                            i_reg     <= scan_idx_reg;
                            ent_i_reg <= ram_rdata;
                        end
                        if (scan_pend_reg && ram_rdata.base <= end_reg - 48'd1)
                        begin
                            j_reg     <= scan_idx_reg;
                            ent_j_reg <= ram_rdata;
                        end
                    end
                    S_DECIDE:
                    begin
                        cur_reg   <= start_reg;
                        rem_reg   <= len_reg;
                        first_reg <= 1'b1;
                        k_reg     <= {1'b0, i_reg} + CNT_W'(1);
                        left_reg  <= (leftlen != 48'd0);
                        right_reg <= (rend > {1'b0, end_reg});
                        newpos_reg   <= newpos_c;
                        newcount_reg <= newcount_c;
                        sh_up_reg    <= (newpos_c > j1_c);
                        sh_left_reg  <= count_reg - CNT_W'(j1_c);
                        sh_rd_reg    <= (newpos_c > j1_c) ? (count_reg - CNT_W'(1))
                                                          : CNT_W'(j1_c);
                        wr_pend_reg  <= 1'b0;
                        if (op_reg == OP_LOOKUP)
                        begin
                            state_reg <= S_LOOK;
                        end
                        else if (newcount_c > (CNT_W+1)'(MAX_EXTENTS))
                        begin
                            st_reg    <= ST_FULL;
                            echo_reg  <= 1'b1;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SHIFT;
                        end
                    end
                    S_LOOK:
                    begin
                        if (out_free)
                        begin
                            first_reg <= 1'b0;
                            if (frag.corrupt)
                            begin
                                out_start_reg  <= start_reg;
                                out_seq_reg    <= 48'd0;
                                out_off_reg    <= 32'd0;
                                out_len_reg    <= len_reg;
                                out_status_reg <= ST_CORRUPT;
                                out_last_reg   <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                out_start_reg  <= frag.start;
                                out_seq_reg    <= frag.seq;
                                out_off_reg    <= frag.off;
                                out_len_reg    <= frag.len;
                                out_status_reg <= ST_OK;
                                out_last_reg   <= frag.last;
                                cur_reg        <= cur_reg + frag.len;
                                rem_reg        <= rem_reg - frag.len;
                                k_reg          <= k_reg + CNT_W'(1);
                                if (frag.last)
                                begin
                                    state_reg <= S_IDLE;
                                end
                            end
                        end
                    end
                    S_SHIFT:
                    begin
                        // tail moves up from the top or down from the bottom so no entry
                        // is overwritten before it is read
                        if (sh_left_reg != '0)
                        begin
                            wr_pend_reg <= 1'b1;
                            wr_addr_reg <= IDX_W'({1'b0, sh_rd_reg} + newpos_reg - j1_c);
                            sh_rd_reg   <= sh_up_reg ? (sh_rd_reg - CNT_W'(1))
                                                     : (sh_rd_reg + CNT_W'(1));
                            sh_left_reg <= sh_left_reg - CNT_W'(1);
                        end
                        else
                        begin
                            wr_pend_reg <= 1'b0;
                            if (!wr_pend_reg)
                            begin
                                state_reg <= S_WLEFT;
                            end
                        end
                    end
                    S_WLEFT:
                    begin
                        state_reg <= S_WNEW;
                    end
                    S_WNEW:
                    begin
                        state_reg <= S_WRIGHT;
                    end
                    S_WRIGHT:
                    begin
                        count_reg <= CNT_W'(newcount_reg);
                        st_reg    <= ST_OK;
                        echo_reg  <= 1'b1;
                        state_reg <= S_RESP;
                    end
                    S_RESP:
                    begin
                        if (out_free)
                        begin
                            out_start_reg  <= start_reg;
                            out_seq_reg    <= echo_reg ? seq_reg : 48'd0;
                            out_off_reg    <= echo_reg ? off_reg : 32'd0;
                            out_len_reg    <= len_reg;
                            out_status_reg <= st_reg;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_EXTENTS)))
        else $error("extent count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> rsp.last)
        else $error("error result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && !cfg_we |=> !req.ready)
        else $error("new request taken while one is in progress");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench of the extent map translate/update block
// depends on emt_pkg, emt_if and the rtl of extent_map_translate_update_core
module testbench;
    import emt_pkg::*;

    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned M32 = 64'hFFFF_FFFF;
    localparam longint unsigned SKIP_TOP = 64'hFFFF_FFFF;
    localparam int RESULT_CAP = 64;
    localparam int SETTLE_CYCLES = 2 * MAX_EXTENTS + 30;
    localparam int STALL_LIMIT = 6000;

    typedef struct {
        logic [47:0] start;
        logic [47:0] seq;
        logic [31:0] off;
        logic [47:0] len;
        logic [1:0]  status;
        logic        last;
    } fragment_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [47:0] cfg_wdata;

    emt_req_if req ();
    emt_rsp_if rsp ();

    extent_map_translate_update_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the extent table
    longint unsigned img_len;
    longint unsigned ext_base [MAX_EXTENTS];
    longint unsigned ext_seq  [MAX_EXTENTS];
    longint unsigned ext_off  [MAX_EXTENTS];
    longint unsigned ext_len  [MAX_EXTENTS];
    int              ext_cnt;

    fragment_t expected_frags[$];
    int        errors;
    int        hold_len;
    bit        no_idle;
    int        quiet_cycles;

    always #4 clk = ~clk;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void enqueue_expected(input fragment_t f);
        expected_frags.insert(expected_frags.size(), f);
    endfunction

    function automatic void table_clear();
        ext_cnt     = 1;
        ext_base[0] = 0;
        ext_seq[0]  = 0;
        ext_off[0]  = 0;
        ext_len[0]  = img_len;
    endfunction

    function automatic int locate(input longint unsigned pos);
        int i;
        i = 0;
        for (int k = 1; k < ext_cnt; k++)
            if (ext_base[k] <= pos)
                i = k;
        return i;
    endfunction

    function automatic void push_frag(input longint unsigned st, input longint unsigned sq,
                                      input longint unsigned of, input longint unsigned ln,
                                      input logic [1:0] status);
        fragment_t f;
        f.start  = st[47:0];
        f.seq    = sq[47:0];
        f.off    = of[31:0];
        f.len    = ln[47:0];
        f.status = status;
        f.last   = 1'b1;
        enqueue_expected(f);
    endfunction

    function automatic void lookup_fragments(input longint unsigned start,
                                             input longint unsigned len);
        fragment_t       pieces[$];
        fragment_t       f;
        longint unsigned found, cur, rem, b, el, sq, of, avail, o, fs, piece, skip;
        int              k, n;
        bit              bad;
        k = locate(start);
        found = 0;
        n = 0;
        bad = 0;
        while (found < len && !bad) begin
            cur = start + found;
            rem = len - found;
            avail = 0;
            o = 0;
            fs = 0;
            if (k >= ext_cnt || n >= RESULT_CAP) begin
                bad = 1;
            end
            else begin
                b  = ext_base[k];
                el = ext_len[k];
                sq = ext_seq[k];
                of = ext_off[k];
                if (b < cur) begin
                    skip = cur - b;
                    if (skip >= SKIP_TOP && sq != 0)
                        bad = 1;
                    // unmapped extents keep their offset on a huge skip
                    o = (of + (skip >= SKIP_TOP ? 0 : skip)) & M32;
                    avail = el > skip ? el - skip : 0;
                    fs = cur;
                end
                else if (b > cur) begin
                    bad = 1;
                end
                else begin
                    o = of;
                    avail = el;
                    fs = b;
                end
                if (!bad && avail == 0)
                    bad = 1;
                if (!bad) begin
                    piece = rem <= avail ? rem : avail;
                    f.start  = fs[47:0];
                    f.seq    = sq[47:0];
                    f.off    = o[31:0];
                    f.len    = piece[47:0];
                    f.status = ST_OK;
                    f.last   = 1'b0;
                    pieces.insert(pieces.size(), f);
                    n++;
                    found += piece;
                    k++;
                end
            end
        end
        if (bad) begin
            push_frag(start, 0, 0, len, ST_CORRUPT);
        end
        else begin
            pieces[pieces.size() - 1].last = 1'b1;
            foreach (pieces[i])
                enqueue_expected(pieces[i]);
        end
    endfunction

    function automatic logic [1:0] map_extent(input longint unsigned start,
                                              input longint unsigned len,
                                              input longint unsigned seq,
                                              input longint unsigned off);
        longint unsigned nb [MAX_EXTENTS];
        longint unsigned ns [MAX_EXTENTS];
        longint unsigned no [MAX_EXTENTS];
        longint unsigned nl [MAX_EXTENTS];
        longint unsigned stop, leftlen, rend;
        int              i, j, newcount, n;
        bit              right;
        stop = start + len;
        i = locate(start);
        j = locate(stop - 1);
        leftlen = start - ext_base[i];
        rend = ext_base[j] + ext_len[j];
        right = rend > stop;
        newcount = i + (leftlen > 0) + 1 + right + (ext_cnt - 1 - j);
        if (newcount > MAX_EXTENTS)
            return ST_FULL;
        n = 0;
        for (int k = 0; k < i; k++) begin
            nb[n] = ext_base[k]; ns[n] = ext_seq[k]; no[n] = ext_off[k]; nl[n] = ext_len[k];
            n++;
        end
        if (leftlen > 0) begin
            nb[n] = ext_base[i]; ns[n] = ext_seq[i]; no[n] = ext_off[i]; nl[n] = leftlen;
            n++;
        end
        nb[n] = start; ns[n] = seq; no[n] = off; nl[n] = len;
        n++;
        if (right) begin
            nb[n] = stop;
            ns[n] = ext_seq[j];
            no[n] = (ext_off[j] + (stop - ext_base[j])) & M32;
            nl[n] = rend - stop;
            n++;
        end
        for (int k = j + 1; k < ext_cnt; k++) begin
            nb[n] = ext_base[k]; ns[n] = ext_seq[k]; no[n] = ext_off[k]; nl[n] = ext_len[k];
            n++;
        end
        for (int k = 0; k < n; k++) begin
            ext_base[k] = nb[k]; ext_seq[k] = ns[k]; ext_off[k] = no[k]; ext_len[k] = nl[k];
        end
        ext_cnt = n;
        return ST_OK;
    endfunction

    function automatic void predict_request(input logic op, input longint unsigned start,
                                            input longint unsigned len,
                                            input longint unsigned seq,
                                            input longint unsigned off_in);
        longint unsigned off;
        logic [1:0]      status;
        off = seq != 0 ? off_in : 0;
        if (start + len > img_len)
            push_frag(start, 0, 0, len, ST_PAST);
        else if (op == OP_LOOKUP && len == 0)
            push_frag(start, 0, 0, 0, ST_OK);
        else if (op == OP_LOOKUP)
            lookup_fragments(start, len);
        else begin
            status = len == 0 ? ST_OK : map_extent(start, len, seq, off);
            push_frag(start, seq, off, len, status);
        end
    endfunction

    // one request; valid stays up across back-to-back transactions
    task automatic send_request(input logic op, input logic [47:0] start,
                                input logic [47:0] len, input logic [47:0] seq,
                                input logic [31:0] off);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.opcode            <= op;
        req.range_start       <= start;
        req.range_length      <= len;
        req.new_seqnum        <= seq;
        req.new_object_offset <= off;
        req.valid             <= 1'b1;
        do @(posedge clk); while (!req.ready);
        predict_request(op, start, len, seq, off);
        @(negedge clk);
    endtask

    task automatic drain();
        if (req.valid)
            req.valid <= 1'b0;
        while (expected_frags.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_image_length(input logic [47:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        img_len = value;
        table_clear();
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom} & M48);
    endfunction

    task automatic test_reset_table();
        send_request(OP_LOOKUP, 0, 48'd1073741824, 0, 0);
        send_request(OP_LOOKUP, 12, 0, 0, 0);
        send_request(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0);
        send_request(OP_MAP, 0, 100, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_MAP, 50, 20, 0, 32'h1234_5678);
        send_request(OP_MAP, 30, 0, 7, 9);
        send_request(OP_LOOKUP, 10, 200, 0, 0);
        send_request(OP_MAP, 48'd1073741823, 2, 3, 3);
        send_request(OP_MAP, 0, 48'd1073741824, 1, 32'hFFFF_FFF0);
        send_request(OP_LOOKUP, 5, 48'd1073741819, 0, 0);
    endtask

    task automatic test_extreme_sizes();
        set_image_length(48'hFFFF_FFFF_FFFF);
        // huge skip into the unmapped extent
        send_request(OP_LOOKUP, 48'h2_0000_0000, 10, 0, 0);
        send_request(OP_MAP, 0, 48'h100_0000_0000, 5, 7);
        // huge skip into a mapped extent walks as corrupt
        send_request(OP_LOOKUP, 48'h2_0000_0000, 10, 0, 0);
        send_request(OP_LOOKUP, 48'hFFFF_FFFD, 4, 0, 0);
        send_request(OP_LOOKUP, 48'hFFFF_FFFE, 4, 0, 0);
        send_request(OP_MAP, 48'hFFFF_FFFF_FFF0, 48'hF, 9, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 0, 48'hFFFF_FFFF_FFFF, 0, 0);
        set_image_length(1);
        send_request(OP_LOOKUP, 0, 1, 0, 0);
        send_request(OP_MAP, 0, 1, 2, 3);
        send_request(OP_LOOKUP, 1, 1, 0, 0);
        send_request(OP_LOOKUP, 0, 1, 0, 0);
    endtask

    task automatic test_table_full();
        set_image_length(1000);
        for (int i = 0; i < 34; i++)
            send_request(OP_MAP, 48'(2 * i + 1), 1, 48'(i + 1), 32'(i));
        send_request(OP_LOOKUP, 0, 1000, 0, 0);
        send_request(OP_MAP, 0, 1000, 0, 0);
        send_request(OP_LOOKUP, 0, 1000, 0, 0);
    endtask

    task automatic random_phase(input logic [47:0] image, input int count,
                                input longint unsigned span);
        longint unsigned start, len, room;
        logic            op;
        logic [47:0]     seq;
        int              pick;
        set_image_length(image);
        no_idle = 0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                no_idle = 1;
            if (i == count / 2 + 10)
                no_idle = 0;
            pick = $urandom_range(0, 99);
            op = $urandom_range(0, 99) < 55;
            seq = $urandom_range(0, 4) == 0 ? 48'd0 : rand48();
            if (pick < 8) begin
                send_request(1'($urandom_range(0, 1)), rand48(), rand48(), rand48(), $urandom);
            end
            else if (pick < 12) begin
                send_request(op, rand48() % image, 0, seq, $urandom);
            end
            else begin
                start = rand48() % image;
                room = image - start;
                if (room > span)
                    room = span;
                len = 1 + rand48() % room;
                send_request(op, 48'(start), 48'(len), seq, $urandom);
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(4096, 50, 600);
        random_phase(48'd1048576, 30, 200000);
        random_phase(48'hFFFF_FFFF_FFFF, 20, 64'h10_0000_0000);
    endtask

    task automatic test_output_backpressure();
        set_image_length(4096);
        send_request(OP_LOOKUP, 0, 4096, 0, 0);
        hold_len = 300;
        for (int i = 0; i < 20; i++)
            send_request(OP_MAP, 48'($urandom_range(0, 4000)), 48'($urandom_range(1, 90)),
                         48'($urandom_range(0, 3)), $urandom);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int w;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_len > 0) begin
                w = hold_len;
                hold_len = 0;
            end
            else
                w = no_idle ? 0 : $urandom_range(0, 9);
            if (w > 0) begin
                rsp.ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        fragment_t e;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (expected_frags.size() == 0)
                report("result transaction with nothing expected");
            else begin
                e = expected_frags.pop_front();
                if (rsp.fragment_start !== e.start)
                    report($sformatf("start %h, want %h", rsp.fragment_start, e.start));
                if (rsp.fragment_seqnum !== e.seq)
                    report($sformatf("seqnum %h, want %h", rsp.fragment_seqnum, e.seq));
                if (rsp.fragment_object_offset !== e.off)
                    report($sformatf("offset %h, want %h", rsp.fragment_object_offset,
                                     e.off));
                if (rsp.fragment_length !== e.len)
                    report($sformatf("length %h, want %h", rsp.fragment_length, e.len));
                if (rsp.status !== e.status)
                    report($sformatf("status %0d, want %0d", rsp.status, e.status));
                if (rsp.last !== e.last)
                    report($sformatf("last %b, want %b", rsp.last, e.last));
            end
        end
    end

    // watchdog on cycles without any transaction or register write
    always @(posedge clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.opcode = OP_LOOKUP;
        req.range_start = '0;
        req.range_length = '0;
        req.new_seqnum = '0;
        req.new_object_offset = '0;
        errors = 0;
        hold_len = 0;
        no_idle = 0;
        quiet_cycles = 0;
        img_len = RESET_IMAGE_LEN;
        table_clear();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_table();
        test_extreme_sizes();
        test_table_full();
        test_random_traffic();
        test_output_backpressure();
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/emt_pkg.sv
rtl/emt_if.sv
rtl/emt_ram.sv
rtl/emt_frag.sv
rtl/extent_map_translate_update_core.sv
tb/testbench.sv
